/* hw/rtl/plbck_pkg.sv */
// Shared types, item codes and field layout for the color-keyed palette line blitter.
`default_nettype none

package plbck_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_HEADER  = 2'd1;
    localparam logic [1:0] MODE_PIXEL   = 2'd2;

    // Default geometry
    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 170;
    localparam int DEF_PALETTE_DEPTH = 256;

    // Fixed field widths
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 8;
    localparam int COLOR_W = 16;
    localparam int COORD_W = 16;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;

    // Stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 40;

    // Line state loaded by a header
    typedef struct packed {
        logic [INDEX_W-1:0] key;
        logic [INDEX_W-1:0] fill;
        logic               restore;
        logic               keyed;
        logic [COL_W-1:0]   origin;
        logic [ROW_W-1:0]   row;
    } line_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/palette_line_blit_with_color_key.sv */
// Top level: color-keyed palette line blitter with RGB565 palette memory.
//
// Usage
//   s_ channel carries three kinds of beats, selected by s_tuser:
//     palette write  - loads palette[entry_index] with entry_color
//     line header    - opens a line at (line_x, line_y), clipped to the screen,
//                      and loads key, background index and the two flags
//     pixel          - one 8-bit palette index of the open line
//   m_ channel carries one beat per drawn pixel: column, row, RGB565 color,
//   and on m_tuser the starts_run flag (first pixel of a new address window).
//   Path: a drawn pixel passes the palette read register, then the output
//   register, on its way from its s_ beat to m_.
//   Throughput: one beat per cycle of any kind while s_tready is high, set by
//   the single palette read port; palette writes use the write port in the
//   accept cycle, so a pixel right after a write already sees the new entry.
//   Reset: line closed, flags cleared, both stages empty. The palette holds
//   no defined value until written and is not cleared.
//   Stall: when m_tready is low the output register holds; the read stage
//   still fills, after which s_tready drops until the output drains.
`default_nettype none

module palette_line_blit_with_color_key
    import plbck_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata, low bit up: entry_index[7:0], entry_color[23:8], line_x[39:24],
    // line_y[55:40], line_width[71:56], key_index[79:72],
    // background_index[87:80], restore_background[88], keyed[89], zeros[95:90]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[1:0]
    input  wire logic [MODE_W-1:0]     s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // m_tdata, low bit up: column[8:0], row[16:9], color[32:17], zeros[39:33]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // m_tuser: starts_run
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready
);

    localparam int PW = $clog2(SCREEN_WIDTH + 1);      // position / width
    localparam int IW = $clog2(PALETTE_DEPTH);         // palette address

    // ---- input field unpack ----
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [COORD_W-1:0] line_x, line_y, line_width;
    logic [INDEX_W-1:0] key_index, background_index;
    logic               restore_background, keyed;

    assign entry_index        = s_tdata[7:0];
    assign entry_color        = s_tdata[23:8];
    assign line_x             = s_tdata[39:24];
    assign line_y             = s_tdata[55:40];
    assign line_width         = s_tdata[71:56];
    assign key_index          = s_tdata[79:72];
    assign background_index   = s_tdata[87:80];
    assign restore_background = s_tdata[88];
    assign keyed              = s_tdata[89];

    // ---- line state ----
    line_cfg_t          cfg_reg, cfg_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      clip_reg, clip_next;
    logic               active_reg, active_next;
    logic               prev_drawn_reg, prev_drawn_next;

    // ---- pipeline ----
    logic               p1_valid_reg, p1_valid_next;
    logic [COL_W-1:0]   p1_col_reg;
    logic [ROW_W-1:0]   p1_row_reg;
    logic               p1_start_reg;
    logic               p1_oor_reg;                    // index past palette end
    logic [COLOR_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic               out_start_reg;

    logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

    logic               accept, advance;
    logic               pal_wr, pix_draw;
    logic [INDEX_W-1:0] eff_index;
    logic [PW-1:0]      room;
    logic               pix_live;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign room     = PW'(SCREEN_WIDTH - int'(line_x[PW-1:0]));
    assign pix_live = active_reg && (pos_reg < clip_reg);

    // restore substitutes the fill index for key pixels
    assign eff_index = (cfg_reg.restore && entry_index == cfg_reg.key) ?
                       cfg_reg.fill : entry_index;

    assign pal_wr = accept && s_tuser == MODE_PALETTE &&
                    ({1'b0, entry_index} < 9'(PALETTE_DEPTH));

    always_comb begin
        cfg_next        = cfg_reg;
        pos_next        = pos_reg;
        clip_next       = clip_reg;
        active_next     = active_reg;
        prev_drawn_next = prev_drawn_reg;
        pix_draw        = 1'b0;
        if (accept) begin
            unique case (s_tuser)
                MODE_HEADER: begin
                    cfg_next.key     = key_index;
                    cfg_next.fill    = background_index;
                    cfg_next.restore = restore_background;
                    cfg_next.keyed   = keyed;
                    cfg_next.origin  = line_x[COL_W-1:0];
                    cfg_next.row     = line_y[ROW_W-1:0];
                    pos_next         = '0;
                    prev_drawn_next  = 1'b0;
                    clip_next        = '0;
                    active_next      = 1'b0;
                    if ((32'(line_x) < 32'(SCREEN_WIDTH)) &&
                        (32'(line_y) < 32'(SCREEN_HEIGHT))) begin
                        clip_next   = (line_width > 16'(room)) ? room
                                                               : PW'(line_width);
                        active_next = (line_width != '0);
                    end
                end
                MODE_PIXEL: begin
                    if (pix_live) begin
                        pos_next = PW'(pos_reg + 1'b1);
                        if (!cfg_reg.restore && cfg_reg.keyed &&
                            entry_index == cfg_reg.key) begin
                            prev_drawn_next = 1'b0;      // transparent: skipped
                        end else begin
                            pix_draw        = 1'b1;
                            prev_drawn_next = 1'b1;
                        end
                    end
                end
                default: ;                              // palette write, unused code
            endcase
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (advance)
            p1_valid_next = 1'b0;
        if (pix_draw)
            p1_valid_next = 1'b1;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = p1_valid_reg;
    end

    // Palette: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (pal_wr)
            palette_mem[entry_index[IW-1:0]] <= entry_color;
        if (pix_draw)
            rd_data_reg <= palette_mem[eff_index[IW-1:0]];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pix_draw) begin
            p1_col_reg   <= COL_W'(cfg_reg.origin + COL_W'(pos_reg));
            p1_row_reg   <= cfg_reg.row;
            p1_start_reg <= !prev_drawn_reg;
            p1_oor_reg   <= ({1'b0, eff_index} >= 9'(PALETTE_DEPTH));
        end
        if (advance && p1_valid_reg) begin
            out_data_reg  <= {7'd0, (p1_oor_reg ? {COLOR_W{1'b0}} : rd_data_reg),
                              p1_row_reg, p1_col_reg};
            out_start_reg <= p1_start_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= '0;
            pos_reg        <= '0;
            clip_reg       <= '0;
            active_reg     <= 1'b0;
            prev_drawn_reg <= 1'b0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            pos_reg        <= pos_next;
            clip_reg       <= clip_next;
            active_reg     <= active_next;
            prev_drawn_reg <= prev_drawn_next;
            p1_valid_reg   <= p1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_start_reg;
    assign m_tvalid = out_valid_reg;

    // ---- checks ----
    a_pos_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= clip_reg)
        else $error("pixel position past clipped width");

    a_active_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> clip_reg != '0)
        else $error("open line with zero width");

    a_draw_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_draw |=> p1_valid_reg)
        else $error("drawn pixel lost before read stage");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && out_valid_reg && !m_tready) |=> p1_valid_reg && out_valid_reg)
        else $error("pipeline beat dropped under stall");

endmodule

`default_nettype wire
